// ----- design/sclseq_pkg.sv -----
// ---------------------------------------------------------------------------
// sclseq_pkg
// Shared codes and types of the card line sequencer: request codes,
// register indexes, the command passed from front to back, hold settings.
// ---------------------------------------------------------------------------
package sclseq_pkg;

  // request codes on req_type
  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_SEND   = 3'd1;
  localparam logic [2:0] REQ_STOP   = 3'd2;
  localparam logic [2:0] REQ_RESET  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;
  localparam logic [2:0] REQ_WAIT   = 3'd5;
  localparam logic [2:0] REQ_SAMPLE = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_FRONT_HOLD = 2'd0;
  localparam logic [1:0] CFG_BIT_HOLD   = 2'd1;
  localparam logic [1:0] CFG_RESET_HOLD = 2'd2;

  localparam logic [15:0] FRONT_HOLD_RST = 16'd10;
  localparam logic [15:0] BIT_HOLD_RST   = 16'd50;
  localparam logic [15:0] RESET_HOLD_RST = 16'd500;

  // command queue between front and back
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // step sequences the back end knows how to play
  typedef enum logic [3:0] {
    OP_START,
    OP_SEND,
    OP_STOP,
    OP_RESET,
    OP_ASK,
    OP_PROC_BEGIN,
    OP_BIT,
    OP_BYTE_MORE,
    OP_BYTE_END,
    OP_PROC_LOW,
    OP_PROC_HIGH
  } op_t;

  // data: byte to send, finished byte or pulse count, depending on op
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] front_hold;
    logic [15:0] bit_hold;
    logic [15:0] reset_hold;
  } hold_cfg_t;

endpackage

// ----- design/sync_card_line_sequencer.sv -----
// ---------------------------------------------------------------------------
// sync_card_line_sequencer
// Line sequencer for a synchronous three-wire memory card master.
// ---------------------------------------------------------------------------
// Each accepted request becomes a list of line steps (clock, I/O value and
// enable, reset level, hold ticks); a step with sample_after set asks the host
// to sample the card I/O after the hold and return it as an io sample request.
// Requests arriving while a sample is awaited, samples arriving while none
// is awaited, and request code 7 are dropped without results. The back-end
// sequencer emits one step per cycle while the output is not stalled; a send
// byte has 24 steps, the others 1 to 5. A 4-entry command queue lets requests
// be taken one per cycle while earlier steps drain; input stalls only when
// that queue is full. Hold registers are written through
// cfg_we/cfg_index/cfg_data; index 3 is ignored.
module sync_card_line_sequencer #(
  parameter int ATR_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic        io_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ck_level,
  output logic        io_value,
  output logic        io_out_en,
  output logic        rst_level,
  output logic [15:0] hold_ticks,
  output logic        sample_after,
  output logic        byte_valid,
  output logic [7:0]  byte_out,
  output logic        count_valid,
  output logic [7:0]  count_out,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sclseq_pkg::hold_cfg_t hold_cfg;
  sclseq_pkg::cmd_t      push_cmd;
  sclseq_pkg::cmd_t      head;
  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  head_valid;
  logic                  accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_cfg.front_hold <= sclseq_pkg::FRONT_HOLD_RST;
      hold_cfg.bit_hold   <= sclseq_pkg::BIT_HOLD_RST;
      hold_cfg.reset_hold <= sclseq_pkg::RESET_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sclseq_pkg::CFG_FRONT_HOLD: hold_cfg.front_hold <= cfg_data;
        sclseq_pkg::CFG_BIT_HOLD:   hold_cfg.bit_hold   <= cfg_data;
        sclseq_pkg::CFG_RESET_HOLD: hold_cfg.reset_hold <= cfg_data;
        default: ;
      endcase
    end
  end

  sclseq_front #(
    .ATR_BYTES (ATR_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req_type),
    .data_byte (data_byte),
    .io_level  (io_level),
    .push      (push),
    .cmd       (push_cmd)
  );

  sclseq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sclseq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .hold_cfg     (hold_cfg),
    .q_valid      (head_valid),
    .q_cmd        (head),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ck_level     (ck_level),
    .io_value     (io_value),
    .io_out_en    (io_out_en),
    .rst_level    (rst_level),
    .hold_ticks   (hold_ticks),
    .sample_after (sample_after),
    .byte_valid   (byte_valid),
    .byte_out     (byte_out),
    .count_valid  (count_valid),
    .count_out    (count_out),
    .last         (last)
  );

endmodule

// ----- design/sclseq_front.sv -----
// ---------------------------------------------------------------------------
// sclseq_front
// Request front end: tracks read/processing progress, drops requests that
// arrive out of turn and turns each accepted one into a step command.
// ---------------------------------------------------------------------------
module sclseq_front #(
  parameter int ATR_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [2:0]        req_type,
  input  logic [7:0]        data_byte,
  input  logic              io_level,
  output logic              push,
  output sclseq_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_READ = 3'b010,
    MODE_PROC = 3'b100
  } mode_t;

  mode_t      mode, mode_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] atr_left, atr_left_next;
  logic [7:0] pulse_count, pulse_count_next;
  logic       gen;
  logic [7:0] filled;
  logic [2:0] atr_dec;

  always_comb begin
    mode_next        = mode;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    atr_left_next    = atr_left;
    pulse_count_next = pulse_count;
    gen              = 1'b0;
    cmd.op           = sclseq_pkg::OP_START;
    cmd.data         = data_byte;
    filled           = shift_byte | (8'(io_level) << bit_index);
    atr_dec          = atr_left - 3'd1;

    if (req_type == sclseq_pkg::REQ_SAMPLE) begin
      case (mode)
        MODE_READ: begin
          gen = 1'b1;
          if (bit_index == 3'd7) begin
            cmd.data        = filled;
            bit_index_next  = 3'd0;
            shift_byte_next = 8'd0;
            atr_left_next   = atr_dec;
            if (atr_dec == 3'd0) begin
              cmd.op    = sclseq_pkg::OP_BYTE_END;
              mode_next = MODE_IDLE;
            end else begin
              cmd.op = sclseq_pkg::OP_BYTE_MORE;
            end
          end else begin
            cmd.op          = sclseq_pkg::OP_BIT;
            bit_index_next  = bit_index + 3'd1;
            shift_byte_next = filled;
          end
        end
        MODE_PROC: begin
          gen = 1'b1;
          if (io_level) begin
            cmd.op    = sclseq_pkg::OP_PROC_HIGH;
            cmd.data  = pulse_count;
            mode_next = MODE_IDLE;
          end else begin
            cmd.op = sclseq_pkg::OP_PROC_LOW;
            if (pulse_count != 8'hFF) begin
              pulse_count_next = pulse_count + 8'd1;
            end
          end
        end
        default: ;
      endcase
    end else if (mode == MODE_IDLE) begin
      case (req_type)
        sclseq_pkg::REQ_START: begin
          gen    = 1'b1;
          cmd.op = sclseq_pkg::OP_START;
        end
        sclseq_pkg::REQ_SEND: begin
          gen    = 1'b1;
          cmd.op = sclseq_pkg::OP_SEND;
        end
        sclseq_pkg::REQ_STOP: begin
          gen    = 1'b1;
          cmd.op = sclseq_pkg::OP_STOP;
        end
        sclseq_pkg::REQ_RESET: begin
          gen             = 1'b1;
          cmd.op          = sclseq_pkg::OP_RESET;
          mode_next       = MODE_READ;
          atr_left_next   = 3'(ATR_BYTES);
          bit_index_next  = 3'd0;
          shift_byte_next = 8'd0;
        end
        sclseq_pkg::REQ_READ: begin
          gen             = 1'b1;
          cmd.op          = sclseq_pkg::OP_ASK;
          mode_next       = MODE_READ;
          atr_left_next   = 3'd1;
          bit_index_next  = 3'd0;
          shift_byte_next = 8'd0;
        end
        sclseq_pkg::REQ_WAIT: begin
          gen              = 1'b1;
          cmd.op           = sclseq_pkg::OP_PROC_BEGIN;
          mode_next        = MODE_PROC;
          pulse_count_next = 8'd0;
        end
        default: ;
      endcase
    end
  end

  assign push = accept && gen;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      bit_index   <= 3'd0;
      shift_byte  <= 8'd0;
      atr_left    <= 3'd0;
      pulse_count <= 8'd0;
    end else if (accept) begin
      mode        <= mode_next;
      bit_index   <= bit_index_next;
      shift_byte  <= shift_byte_next;
      atr_left    <= atr_left_next;
      pulse_count <= pulse_count_next;
    end
  end

endmodule

// ----- design/sclseq_queue.sv -----
// ---------------------------------------------------------------------------
// sclseq_queue
// Small command FIFO between the front end and the step sequencer.
// ---------------------------------------------------------------------------
module sclseq_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sclseq_pkg::cmd_t  push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output sclseq_pkg::cmd_t  head
);

  sclseq_pkg::cmd_t                 entries [sclseq_pkg::QUEUE_DEPTH];
  logic [sclseq_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [sclseq_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [sclseq_pkg::QUEUE_AW:0]    count;

  assign full       = count == (sclseq_pkg::QUEUE_AW + 1)'(sclseq_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");
`endif

endmodule

// ----- design/sclseq_back.sv -----
// ---------------------------------------------------------------------------
// sclseq_back
// Step sequencer: plays a command as line steps, one step per cycle into
// the output register when not stalled, and keeps the card line levels.
// ---------------------------------------------------------------------------
module sclseq_back (
  input  logic                  clk,
  input  logic                  rst,
  input  sclseq_pkg::hold_cfg_t hold_cfg,
  input  logic                  q_valid,
  input  sclseq_pkg::cmd_t      q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  ck_level,
  output logic                  io_value,
  output logic                  io_out_en,
  output logic                  rst_level,
  output logic [15:0]           hold_ticks,
  output logic                  sample_after,
  output logic                  byte_valid,
  output logic [7:0]            byte_out,
  output logic                  count_valid,
  output logic [7:0]            count_out,
  output logic                  last
);

  typedef enum logic [1:0] {
    HOLD_ZERO,
    HOLD_FRONT,
    HOLD_BIT,
    HOLD_RESET
  } hold_sel_t;

  // step: position within the sequence; bitc: bit of a byte being sent
  logic [2:0] step, bitc;
  logic       ck, io, en, rs;
  logic       ck_next, io_next, en_next, rs_next;
  hold_sel_t  hsel;
  logic       smp, bv, cv, lst;
  logic       load;
  logic [15:0] hold_val;

  assign load  = q_valid && (!out_valid || !out_stall);
  assign q_pop = load && lst;

  always_comb begin
    ck_next = ck;
    io_next = io;
    en_next = en;
    rs_next = rs;
    hsel    = HOLD_BIT;
    smp     = 1'b0;
    bv      = 1'b0;
    cv      = 1'b0;
    lst     = 1'b0;
    case (q_cmd.op)
      sclseq_pkg::OP_START: begin
        case (step)
          3'd0: begin
            en_next = 1'b1;
            io_next = 1'b1;
            ck_next = 1'b1;
          end
          3'd1: begin
            io_next = 1'b0;
            hsel    = HOLD_FRONT;
          end
          default: begin
            ck_next = 1'b0;
            lst     = 1'b1;
          end
        endcase
      end
      sclseq_pkg::OP_SEND: begin
        case (step)
          3'd0: begin
            io_next = q_cmd.data[bitc];
            hsel    = HOLD_FRONT;
          end
          3'd1: ck_next = 1'b1;
          default: begin
            ck_next = 1'b0;
            lst     = bitc == 3'd7;
          end
        endcase
      end
      sclseq_pkg::OP_STOP: begin
        case (step)
          3'd0: begin
            io_next = 1'b0;
            hsel    = HOLD_FRONT;
          end
          3'd1: begin
            ck_next = 1'b1;
            hsel    = HOLD_FRONT;
          end
          3'd2: begin
            io_next = 1'b1;
            en_next = 1'b0;
          end
          default: begin
            ck_next = 1'b0;
            lst     = 1'b1;
          end
        endcase
      end
      sclseq_pkg::OP_RESET: begin
        case (step)
          3'd0: begin
            io_next = 1'b1;
            en_next = 1'b0;
            rs_next = 1'b1;
            hsel    = HOLD_FRONT;
          end
          3'd1: begin
            ck_next = 1'b1;
            hsel    = HOLD_RESET;
          end
          3'd2: begin
            ck_next = 1'b0;
            hsel    = HOLD_FRONT;
          end
          3'd3: rs_next = 1'b0;
          default: begin
            ck_next = 1'b1;
            hsel    = HOLD_ZERO;
            smp     = 1'b1;
            lst     = 1'b1;
          end
        endcase
      end
      sclseq_pkg::OP_ASK: begin
        ck_next = 1'b1;
        hsel    = HOLD_ZERO;
        smp     = 1'b1;
        lst     = 1'b1;
      end
      sclseq_pkg::OP_PROC_BEGIN: begin
        hsel = HOLD_ZERO;
        smp  = 1'b1;
        lst  = 1'b1;
      end
      sclseq_pkg::OP_BIT, sclseq_pkg::OP_BYTE_MORE: begin
        // clock is already high from the sample request
        case (step)
          3'd0: ;
          3'd1: begin
            ck_next = 1'b0;
            bv      = q_cmd.op == sclseq_pkg::OP_BYTE_MORE;
          end
          default: begin
            ck_next = 1'b1;
            hsel    = HOLD_ZERO;
            smp     = 1'b1;
            lst     = 1'b1;
          end
        endcase
      end
      sclseq_pkg::OP_BYTE_END: begin
        if (step != 3'd0) begin
          ck_next = 1'b0;
          bv      = 1'b1;
          lst     = 1'b1;
        end
      end
      sclseq_pkg::OP_PROC_LOW, sclseq_pkg::OP_PROC_HIGH: begin
        if (step == 3'd0) begin
          ck_next = 1'b1;
        end else begin
          ck_next = 1'b0;
          smp     = q_cmd.op == sclseq_pkg::OP_PROC_LOW;
          cv      = q_cmd.op == sclseq_pkg::OP_PROC_HIGH;
          lst     = 1'b1;
        end
      end
      default: lst = 1'b1;
    endcase
  end

  always_comb begin
    case (hsel)
      HOLD_ZERO:  hold_val = 16'd0;
      HOLD_FRONT: hold_val = hold_cfg.front_hold;
      HOLD_RESET: hold_val = hold_cfg.reset_hold;
      default:    hold_val = hold_cfg.bit_hold;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 3'd0;
      bitc      <= 3'd0;
      ck        <= 1'b0;
      io        <= 1'b1;
      en        <= 1'b0;
      rs        <= 1'b0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      ck        <= ck_next;
      io        <= io_next;
      en        <= en_next;
      rs        <= rs_next;
      if (lst) begin
        step <= 3'd0;
        bitc <= 3'd0;
      end else if (q_cmd.op == sclseq_pkg::OP_SEND && step == 3'd2) begin
        step <= 3'd0;
        bitc <= bitc + 3'd1;
      end else begin
        step <= step + 3'd1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ck_level     <= ck_next;
      io_value     <= io_next;
      io_out_en    <= en_next;
      rst_level    <= rs_next;
      hold_ticks   <= hold_val;
      sample_after <= smp;
      byte_valid   <= bv;
      byte_out     <= bv ? q_cmd.data : 8'd0;
      count_valid  <= cv;
      count_out    <= cv ? q_cmd.data : 8'd0;
      last         <= lst;
    end
  end

`ifndef SYNTHESIS
  a_sample_ends_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_after |-> last)
    else $error("sample request not on the final step");

  a_one_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(byte_valid && count_valid))
    else $error("byte and count on the same step");

  a_send_phase: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_cmd.op == sclseq_pkg::OP_SEND |-> step <= 3'd2)
    else $error("send phase out of range");

  a_bitc_idle: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_cmd.op != sclseq_pkg::OP_SEND |-> bitc == 3'd0)
    else $error("bit counter left over from a send");
`endif

endmodule

// ----- test/sync_card_line_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sync_card_line_sequencer_tb
// Self-checking bench for the card line sequencer. A queue of requests and
// io samples feeds a clocked driver. A line-step predictor runs on every
// accepted request and queues the steps it expects. A clocked monitor checks
// each returned step, field by field, against the oldest of those steps.
// The run has several phases, each with its own hold settings; some add
// sender gaps, receiver stalls or both. One phase holds the output off
// long enough for the input to back up.
// ---------------------------------------------------------------------------
module sync_card_line_sequencer_tb;

  localparam int          ATR_COUNT      = 4;
  localparam logic [2:0]  REQ_UNDEF      = 3'd7;
  localparam logic [1:0]  CFG_UNUSED     = 2'd3;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          HOLDOFF_CYCLES = 400;
  localparam int          PRESSURE_PHASE = 5;
  localparam int          CYCLE_LIMIT    = 500000;

  typedef enum logic [1:0] {WAIT_IDLE, WAIT_READ, WAIT_PROC} wait_mode_t;

  typedef struct packed {
    logic [2:0] req;
    logic [7:0] data;
    logic       lvl;
  } card_req_t;

  typedef struct packed {
    logic        ck;
    logic        io;
    logic        en;
    logic        rl;
    logic [15:0] hold;
    logic        smp;
    logic        bv;
    logic [7:0]  bo;
    logic        cv;
    logic [7:0]  co;
    logic        lst;
  } line_step_t;

  logic        clk;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [2:0]  req_type     = sclseq_pkg::REQ_START;
  logic [7:0]  data_byte    = 8'h00;
  logic        io_level     = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        ck_level;
  logic        io_value;
  logic        io_out_en;
  logic        rst_level;
  logic [15:0] hold_ticks;
  logic        sample_after;
  logic        byte_valid;
  logic [7:0]  byte_out;
  logic        count_valid;
  logic [7:0]  count_out;
  logic        last;
  logic        cfg_we       = 1'b0;
  logic [1:0]  cfg_index    = sclseq_pkg::CFG_FRONT_HOLD;
  logic [15:0] cfg_data     = 16'h0000;

  sync_card_line_sequencer #(.ATR_BYTES(ATR_COUNT)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .data_byte   (data_byte),
    .io_level    (io_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ck_level    (ck_level),
    .io_value    (io_value),
    .io_out_en   (io_out_en),
    .rst_level   (rst_level),
    .hold_ticks  (hold_ticks),
    .sample_after(sample_after),
    .byte_valid  (byte_valid),
    .byte_out    (byte_out),
    .count_valid (count_valid),
    .count_out   (count_out),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  card_req_t  pending_reqs[$];
  line_step_t expected_steps[$];
  int         reqs_in_flight = 0;
  int         live_reqs      = 0;
  int         fails          = 0;
  int         cycle_count    = 0;
  int         phase          = 0;
  int         tx_idle_pct    = 0;
  int         rx_stall_pct   = 0;
  int         holdoff_cnt    = 0;
  logic       pressure_done  = 1'b0;

  // predictor copy of the hold registers and the line state
  logic [15:0] front_ticks = sclseq_pkg::FRONT_HOLD_RST;
  logic [15:0] bit_ticks   = sclseq_pkg::BIT_HOLD_RST;
  logic [15:0] reset_ticks = sclseq_pkg::RESET_HOLD_RST;
  logic        clock_line  = 1'b0;
  logic        io_port     = 1'b1;
  logic        io_drive    = 1'b0;
  logic        reset_line  = 1'b0;
  wait_mode_t  wait_mode   = WAIT_IDLE;
  logic [2:0]  bit_idx     = 3'd0;
  logic [7:0]  shift_byte  = 8'h00;
  logic [2:0]  atr_left    = 3'd0;
  logic [7:0]  pulse_count = 8'h00;
  int          steps_made;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // line-step predictor
  // ------------------------------------------------------------------
  task automatic push_step(input logic [15:0] hold, input logic smp, input logic bv,
                           input logic [7:0] bo, input logic cv, input logic [7:0] co);
    line_step_t s;
    s = '{ck: clock_line, io: io_port, en: io_drive, rl: reset_line, hold: hold,
          smp: smp, bv: bv, bo: bo, cv: cv, co: co, lst: 1'b0};
    expected_steps.push_back(s);
    steps_made++;
  endtask

  task automatic raise_for_sample();
    clock_line = 1'b1;
    push_step(16'd0, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00);
  endtask

  task automatic predict_steps(input logic [2:0] req, input logic [7:0] data,
                               input logic lvl);
    line_step_t s;
    logic [7:0] done_byte;
    steps_made = 0;
    if (req == sclseq_pkg::REQ_SAMPLE) begin
      if (wait_mode == WAIT_READ) begin
        shift_byte[bit_idx] = lvl;
        push_step(bit_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
        clock_line = 1'b0;
        if (bit_idx == 3'd7) begin
          done_byte  = shift_byte;
          bit_idx    = 3'd0;
          shift_byte = 8'h00;
          atr_left   = atr_left - 3'd1;
          push_step(bit_ticks, 1'b0, 1'b1, done_byte, 1'b0, 8'h00);
          if (atr_left == 3'd0) wait_mode = WAIT_IDLE;
          else raise_for_sample();
        end else begin
          bit_idx = bit_idx + 3'd1;
          push_step(bit_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
          raise_for_sample();
        end
      end else if (wait_mode == WAIT_PROC) begin
        clock_line = 1'b1;
        push_step(bit_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
        clock_line = 1'b0;
        if (lvl) begin
          wait_mode = WAIT_IDLE;
          push_step(bit_ticks, 1'b0, 1'b0, 8'h00, 1'b1, pulse_count);
        end else begin
          if (pulse_count != 8'hFF) pulse_count = pulse_count + 8'd1;
          push_step(bit_ticks, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00);
        end
      end
    end else if (wait_mode == WAIT_IDLE) begin
      case (req)
        sclseq_pkg::REQ_START: begin
          io_drive   = 1'b1;
          io_port    = 1'b1;
          clock_line = 1'b1;
          push_step(bit_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
          io_port = 1'b0;
          push_step(front_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
          clock_line = 1'b0;
          push_step(bit_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
        end
        sclseq_pkg::REQ_SEND: begin
          for (int i = 0; i < 8; i++) begin
            io_port = data[i];
            push_step(front_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
            clock_line = 1'b1;
            push_step(bit_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
            clock_line = 1'b0;
            push_step(bit_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
          end
        end
        sclseq_pkg::REQ_STOP: begin
          io_port = 1'b0;
          push_step(front_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
          clock_line = 1'b1;
          push_step(front_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
          io_port  = 1'b1;
          io_drive = 1'b0;
          push_step(bit_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
          clock_line = 1'b0;
          push_step(bit_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
        end
        sclseq_pkg::REQ_RESET: begin
          io_port    = 1'b1;
          io_drive   = 1'b0;
          reset_line = 1'b1;
          push_step(front_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
          clock_line = 1'b1;
          push_step(reset_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
          clock_line = 1'b0;
          push_step(front_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
          reset_line = 1'b0;
          push_step(bit_ticks, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
          wait_mode  = WAIT_READ;
          atr_left   = 3'(ATR_COUNT);
          bit_idx    = 3'd0;
          shift_byte = 8'h00;
          raise_for_sample();
        end
        sclseq_pkg::REQ_READ: begin
          wait_mode  = WAIT_READ;
          atr_left   = 3'd1;
          bit_idx    = 3'd0;
          shift_byte = 8'h00;
          raise_for_sample();
        end
        sclseq_pkg::REQ_WAIT: begin
          wait_mode   = WAIT_PROC;
          pulse_count = 8'h00;
          push_step(16'd0, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00);
        end
        default: ;
      endcase
    end
    if (steps_made > 0) begin
      s = expected_steps.pop_back();
      s.lst = 1'b1;
      expected_steps.push_back(s);
    end
  endtask

  // ------------------------------------------------------------------
  // request driver
  // ------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    card_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_steps(req_type, data_byte, io_level);
        reqs_in_flight--;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_valid  <= 1'b1;
          req_type  <= nxt.req;
          data_byte <= nxt.data;
          io_level  <= nxt.lvl;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off in the pressure phase
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (phase == PRESSURE_PHASE && !pressure_done) begin
      if (holdoff_cnt == HOLDOFF_CYCLES) begin
        pressure_done <= 1'b1;
        out_stall     <= 1'b0;
      end else begin
        holdoff_cnt <= holdoff_cnt + 1;
        out_stall   <= 1'b1;
      end
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // ------------------------------------------------------------------
  // step monitor
  // ------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : check_steps
    line_step_t s;
    if (!rst && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        $display("%0t unexpected step: expected none, got hold %0h last %0b",
                 $time, hold_ticks, last);
        fails++;
      end else begin
        s = expected_steps.pop_front();
        check_field("ck_level", 16'(s.ck), 16'(ck_level));
        check_field("io_value", 16'(s.io), 16'(io_value));
        check_field("io_out_en", 16'(s.en), 16'(io_out_en));
        check_field("rst_level", 16'(s.rl), 16'(rst_level));
        check_field("hold_ticks", s.hold, hold_ticks);
        check_field("sample_after", 16'(s.smp), 16'(sample_after));
        check_field("byte_valid", 16'(s.bv), 16'(byte_valid));
        check_field("byte_out", 16'(s.bo), 16'(byte_out));
        check_field("count_valid", 16'(s.cv), 16'(count_valid));
        check_field("count_out", 16'(s.co), 16'(count_out));
        check_field("last", 16'(s.lst), 16'(last));
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus building
  // ------------------------------------------------------------------
  task automatic queue_req(input logic [2:0] req, input logic [7:0] data,
                           input logic lvl, input bit live);
    card_req_t r;
    r = '{req: req, data: data, lvl: lvl};
    pending_reqs.push_back(r);
    reqs_in_flight++;
    if (live) live_reqs++;
  endtask

  // a request while a sample is awaited is dropped
  task automatic queue_busy_noise(input int pct);
    logic [2:0] r;
    if ($urandom_range(99) < pct) begin
      r = 3'($urandom_range(6));
      if (r == sclseq_pkg::REQ_SAMPLE) r = REQ_UNDEF;
      queue_req(r, 8'($urandom), 1'($urandom), 1'b0);
    end
  endtask

  task automatic queue_read_bits(input int nbits);
    repeat (nbits) begin
      queue_busy_noise(15);
      queue_req(sclseq_pkg::REQ_SAMPLE, 8'($urandom), 1'($urandom), 1'b1);
    end
  endtask

  task automatic queue_read_byte();
    queue_req(sclseq_pkg::REQ_READ, 8'($urandom), 1'($urandom), 1'b1);
    queue_read_bits(8);
  endtask

  task automatic queue_atr();
    queue_req(sclseq_pkg::REQ_RESET, 8'($urandom), 1'($urandom), 1'b1);
    queue_read_bits(8 * ATR_COUNT);
  endtask

  task automatic queue_proc(input int lows);
    queue_req(sclseq_pkg::REQ_WAIT, 8'($urandom), 1'($urandom), 1'b1);
    repeat (lows) begin
      queue_busy_noise(10);
      queue_req(sclseq_pkg::REQ_SAMPLE, 8'($urandom), 1'b0, 1'b1);
    end
    queue_busy_noise(10);
    queue_req(sclseq_pkg::REQ_SAMPLE, 8'($urandom), 1'b1, 1'b1);
  endtask

  // start, three command bytes, stop
  task automatic queue_frame();
    queue_req(sclseq_pkg::REQ_START, 8'($urandom), 1'($urandom), 1'b1);
    repeat (3) queue_req(sclseq_pkg::REQ_SEND, 8'($urandom), 1'($urandom), 1'b1);
    queue_req(sclseq_pkg::REQ_STOP, 8'($urandom), 1'($urandom), 1'b1);
  endtask

  task automatic queue_random(input int target);
    int first;
    int pick;
    int cut;
    first = live_reqs;
    while (live_reqs - first < target) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        queue_frame();
        if ($urandom_range(1)) repeat ($urandom_range(3, 1)) queue_read_byte();
        else queue_proc($urandom_range(6));
      end else if (pick < 48) begin
        queue_atr();
      end else if (pick < 75) begin
        case ($urandom_range(4))
          0: queue_req(sclseq_pkg::REQ_START, 8'($urandom), 1'($urandom), 1'b1);
          1: queue_req(sclseq_pkg::REQ_SEND, 8'($urandom), 1'($urandom), 1'b1);
          2: queue_req(sclseq_pkg::REQ_STOP, 8'($urandom), 1'($urandom), 1'b1);
          3: queue_read_byte();
          default: queue_proc($urandom_range(3));
        endcase
      end else if (pick < 90) begin
        // idle: a stray sample or the unused code is dropped
        queue_req($urandom_range(1) ? sclseq_pkg::REQ_SAMPLE : REQ_UNDEF, 8'($urandom),
                  1'($urandom), 1'b0);
      end else begin
        // read interrupted by a burst of dropped requests
        cut = $urandom_range(7);
        queue_req(sclseq_pkg::REQ_READ, 8'($urandom), 1'($urandom), 1'b1);
        queue_read_bits(cut);
        repeat (3) queue_busy_noise(100);
        queue_read_bits(8 - cut);
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      sclseq_pkg::CFG_FRONT_HOLD: front_ticks = val;
      sclseq_pkg::CFG_BIT_HOLD:   bit_ticks   = val;
      sclseq_pkg::CFG_RESET_HOLD: reset_ticks = val;
      default: ;
    endcase
  endtask

  task automatic set_holds(input logic [15:0] f, input logic [15:0] b,
                           input logic [15:0] r);
    write_reg(sclseq_pkg::CFG_FRONT_HOLD, f);
    write_reg(sclseq_pkg::CFG_BIT_HOLD, b);
    write_reg(sclseq_pkg::CFG_RESET_HOLD, r);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drain();
    while (reqs_in_flight != 0 || expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic start_phase(input int num, input int tx_pct, input int rx_pct);
    phase        = num;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // ------------------------------------------------------------------
  // phases
  // ------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset holds, extremes of the byte, every request but reset
    start_phase(0, 0, 0);
    queue_req(sclseq_pkg::REQ_START, 8'h00, 1'b0, 1'b1);
    queue_req(sclseq_pkg::REQ_SEND, 8'h00, 1'b0, 1'b1);
    queue_req(sclseq_pkg::REQ_SEND, 8'hFF, 1'b1, 1'b1);
    queue_req(sclseq_pkg::REQ_STOP, 8'hFF, 1'b1, 1'b1);
    queue_req(sclseq_pkg::REQ_READ, 8'h00, 1'b0, 1'b1);
    for (int i = 0; i < 8; i++) begin
      if (i == 3) begin
        queue_req(sclseq_pkg::REQ_START, 8'hFF, 1'b1, 1'b0);
        queue_req(REQ_UNDEF, 8'h00, 1'b0, 1'b0);
      end
      queue_req(sclseq_pkg::REQ_SAMPLE, 8'h00, 1'(i % 2 == 0), 1'b1);
    end
    queue_req(sclseq_pkg::REQ_WAIT, 8'h00, 1'b0, 1'b1);
    queue_req(sclseq_pkg::REQ_SEND, 8'hA5, 1'b0, 1'b0);
    queue_req(sclseq_pkg::REQ_SAMPLE, 8'h00, 1'b0, 1'b1);
    queue_req(sclseq_pkg::REQ_SAMPLE, 8'h00, 1'b1, 1'b1);
    queue_req(sclseq_pkg::REQ_SAMPLE, 8'h00, 1'b1, 1'b0);
    queue_req(REQ_UNDEF, 8'hFF, 1'b1, 1'b0);
    queue_req(sclseq_pkg::REQ_WAIT, 8'hFF, 1'b1, 1'b1);
    queue_req(sclseq_pkg::REQ_SAMPLE, 8'hFF, 1'b1, 1'b1);
    wait_drain();

    // zero holds, one answer-to-reset, a processing wait
    write_reg(CFG_UNUSED, 16'($urandom));
    set_holds(16'd0, 16'd0, 16'd0);
    start_phase(1, 0, 0);
    queue_atr();
    queue_proc(6);
    wait_drain();

    set_holds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    start_phase(2, 66, 0);
    queue_random(12);
    wait_drain();

    set_holds(16'($urandom), 16'($urandom), 16'($urandom));
    start_phase(3, 0, 66);
    queue_random(12);
    wait_drain();

    set_holds(16'($urandom_range(9, 1)), 16'($urandom_range(9, 1)),
              16'($urandom_range(9, 1)));
    start_phase(4, 16, 16);
    queue_random(12);
    wait_drain();

    // output held off at the start while requests keep coming
    set_holds(16'($urandom), 16'($urandom), 16'($urandom));
    queue_random(12);
    start_phase(PRESSURE_PHASE, 0, 0);
    wait_drain();

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
